>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Assert that prop holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Assert prop including during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> rtl/dsh_pkg.sv
// Package for the height map generator: constants and shared types.
`default_nettype none
package dsh_pkg;
   localparam int MAX_ORDER = 8;
   localparam int SIDE_MAX  = (1 << MAX_ORDER) + 1;
   localparam int CW        = $clog2(SIDE_MAX);
   localparam int AW        = $clog2(SIDE_MAX * SIDE_MAX);
   localparam int OW        = 4;
   localparam int HW        = 16;
   localparam logic signed [HW-1:0] HALF_Q = 16'sd8192;
   localparam int QDEPTH    = 4;
   // ceil(2^17 / 3): exact floor division by three for magnitudes below 2^17.
   localparam logic [HW-1:0] THIRD_RECIP = 16'd43691;

   // Command handed from the front part to the back part.
   typedef struct packed {
      logic          start;
      logic [CW-1:0] side_m1;   // side minus one
      logic [CW-1:0] row;
      logic [CW-1:0] col;
      logic [CW-1:0] half;
      logic          diamond;
      logic [OW-1:0] shift;
      logic [HW-1:0] rnd;
      logic          last;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CORNER, ST_READ, ST_CALC, ST_EMIT
   } back_state_type;

   function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
      return AW'(int'(r) * SIDE_MAX + int'(c));
   endfunction
endpackage
`default_nettype wire

>>> rtl/diamond_square_heightmap.sv
// Top level of the diamond-square height map generator.
//  channel | direction | handshake        | payload
//  req     | in        | push / full      | kind, random_value
//  rsp     | out       | pop / empty      | row, col, height, last
//  csr     | in        | we, no wait      | grid_order
// A random item passes the back part in order: pick-up of the command, four
// neighbour reads from the single-port height store, a wait for the last read to return,
// then the write and result. A start item has pick-up, then four corner results, one
// per cycle while results are popped. A result not yet popped stalls the back part.
// The front part takes an item per cycle while its four-entry command queue has room.
// Reset is synchronous; the height store is not cleared and needs a start item.
`default_nettype none
module diamond_square_heightmap (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_kind,
   input  wire logic [15:0] req_random_value,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [8:0]       rsp_row,
   output logic [8:0]       rsp_col,
   output logic signed [15:0] rsp_height,
   output logic             rsp_last,
   input  wire logic        csr_we,
   input  wire logic [3:0]  csr_wdata
);
   logic [3:0] order_ff;
   logic in_ready, fv, fr, qv, qr, ov;
   dsh_pkg::cmd_type fc, qc;
   logic [dsh_pkg::CW-1:0] r, c;

   always_ff @(posedge clock) begin
      if (reset) order_ff <= 4'd8;
      else if (csr_we) order_ff <= csr_wdata;
   end

   dsh_front u_front (.clock(clock), .reset(reset), .grid_order(order_ff),
      .in_valid(req_push), .in_kind(req_kind), .in_rnd(req_random_value),
      .in_ready(in_ready), .cmd_valid(fv), .cmd(fc), .cmd_ready(fr));
   dsh_queue u_queue (.clock(clock), .reset(reset), .wr_valid(fv), .wr_data(fc),
      .wr_ready(fr), .rd_valid(qv), .rd_data(qc), .rd_ready(qr));
   dsh_back u_back (.clock(clock), .reset(reset), .cmd_valid(qv), .cmd(qc),
      .cmd_ready(qr), .out_valid(ov), .out_row(r), .out_col(c),
      .out_height(rsp_height), .out_last(rsp_last), .out_ready(rsp_pop));

   assign req_full = !in_ready;
   assign rsp_empty = !ov;
   assign rsp_row = 9'(r);
   assign rsp_col = 9'(c);
endmodule
`default_nettype wire

>>> rtl/dsh_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module dsh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

>>> rtl/dsh_front.sv
// Front: tracks the visiting order; starts and live samples become commands.
`default_nettype none
`include "assert_macros.svh"
module dsh_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [dsh_pkg::OW-1:0] grid_order,
   input  wire logic                 in_valid,
   input  wire logic                 in_kind,
   input  wire logic [dsh_pkg::HW-1:0] in_rnd,
   output logic                      in_ready,
   output logic                      cmd_valid,
   output dsh_pkg::cmd_type          cmd,
   input  wire logic                 cmd_ready
);
   localparam int CW = dsh_pkg::CW;
   logic [CW-1:0] side_m1_ff, side_m1_in, step_ff, step_in, row_ff, row_in, col_ff, col_in;
   logic [dsh_pkg::OW-1:0] shift_ff, shift_in;
   logic diamond_ff, diamond_in, parity_ff, parity_in, run_ff, run_in;
   logic [dsh_pkg::OW-1:0] ord;
   logic [CW:0] side_new, nc, nr;
   logic [CW-1:0] half;
   logic take;

   assign in_ready = cmd_ready;
   assign take = in_valid && cmd_ready;
   assign half = step_ff >> 1;

   always_comb begin
      ord = grid_order;
      if (ord < 4'd1) ord = 4'd1;
      if (ord > 4'(dsh_pkg::MAX_ORDER)) ord = 4'(dsh_pkg::MAX_ORDER);
      side_new = (CW+1)'(1) << ord;
      side_m1_in = side_m1_ff; step_in = step_ff; row_in = row_ff; col_in = col_ff;
      shift_in = shift_ff; diamond_in = diamond_ff; parity_in = parity_ff; run_in = run_ff;
      nc = {1'b0, col_ff} + {1'b0, step_ff};
      nr = '0;
      cmd = '0;
      cmd.rnd = in_rnd;
      cmd.half = half;
      cmd.shift = shift_ff;
      cmd.diamond = diamond_ff;
      cmd.side_m1 = side_m1_ff;
      cmd.row = row_ff;
      cmd.col = col_ff;
      cmd_valid = 1'b0;
      if (take && !in_kind) begin
         cmd_valid = 1'b1;
         cmd.start = 1'b1;
         cmd.side_m1 = side_new[CW-1:0];
         side_m1_in = side_new[CW-1:0];
         step_in = side_new[CW-1:0];
         shift_in = 4'd2; row_in = '0; col_in = '0;
         diamond_in = 1'b0; parity_in = 1'b0; run_in = 1'b1;
      end else if (take && run_ff) begin
         cmd_valid = 1'b1;
         if (!diamond_ff) begin
            col_in = nc[CW-1:0];
            if (nc >= {1'b0, side_m1_ff}) begin
               col_in = '0;
               nr = {1'b0, row_ff} + {1'b0, step_ff};
               row_in = nr[CW-1:0];
               if (nr >= {1'b0, side_m1_ff}) begin
                  diamond_in = 1'b1; row_in = '0; parity_in = 1'b0; col_in = half;
               end
            end
         end else begin
            col_in = nc[CW-1:0];
            if (nc > {1'b0, side_m1_ff}) begin
               nr = {1'b0, row_ff} + {1'b0, half};
               row_in = nr[CW-1:0];
               parity_in = !parity_ff;
               col_in = parity_in ? '0 : half;
               if (nr > {1'b0, side_m1_ff}) begin
                  step_in = half;
                  shift_in = shift_ff + 4'd1;
                  diamond_in = 1'b0; row_in = '0; col_in = '0; parity_in = 1'b0;
                  if (half <= CW'(1)) begin
                     run_in = 1'b0;
                     cmd.last = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_m1_ff <= CW'(1 << dsh_pkg::MAX_ORDER);
         step_ff <= CW'(1 << dsh_pkg::MAX_ORDER);
         shift_ff <= 4'd2; row_ff <= '0; col_ff <= '0;
         diamond_ff <= 1'b0; parity_ff <= 1'b0; run_ff <= 1'b0;
      end else begin
         side_m1_ff <= side_m1_in; step_ff <= step_in; shift_ff <= shift_in;
         row_ff <= row_in; col_ff <= col_in; diamond_ff <= diamond_in;
         parity_ff <= parity_in; run_ff <= run_in;
      end
   end

   `ASSERT_CLK(a_cmd_needs_take, clock, reset, cmd_valid |-> take, "command without input transfer")
   `ASSERT_CLK(a_last_stops, clock, reset, (cmd_valid && cmd.last) |=> !run_ff, "map still running after last")
   `ASSERT_CLK(a_step_pow2, clock, reset, $onehot(step_ff), "level step not a power of two")
endmodule
`default_nettype wire

>>> rtl/dsh_queue.sv
// Short command queue between the front and back parts.
`default_nettype none
`include "assert_macros.svh"
module dsh_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_valid,
   input  wire dsh_pkg::cmd_type wr_data,
   output logic                  wr_ready,
   output logic                  rd_valid,
   output dsh_pkg::cmd_type      rd_data,
   input  wire logic             rd_ready
);
   localparam int PW = $clog2(dsh_pkg::QDEPTH);
   dsh_pkg::cmd_type slot_ff [dsh_pkg::QDEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0] cnt_ff, cnt_in;
   logic push, pop;

   assign wr_ready = cnt_ff != (PW+1)'(dsh_pkg::QDEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data = slot_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop = rd_valid && rd_ready;

   always_comb begin
      wp_in = push ? wp_ff + PW'(1) : wp_ff;
      rp_in = pop ? rp_ff + PW'(1) : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   `ASSERT_CLK(a_no_overflow, clock, reset, cnt_ff <= (PW+1)'(dsh_pkg::QDEPTH), "queue overflow")
   `ASSERT_CLK(a_ptr_gap, clock, reset, (wp_ff - rp_ff) == cnt_ff[PW-1:0], "queue pointers disagree")
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rd_valid, "queue not empty after reset")
endmodule
`default_nettype wire

>>> rtl/dsh_back.sv
// Back part: reads neighbours, computes heights, writes the store, presents results.
`default_nettype none
`include "assert_macros.svh"
module dsh_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_valid,
   input  wire dsh_pkg::cmd_type     cmd,
   output logic                      cmd_ready,
   output logic                      out_valid,
   output logic [dsh_pkg::CW-1:0]    out_row,
   output logic [dsh_pkg::CW-1:0]    out_col,
   output logic signed [dsh_pkg::HW-1:0] out_height,
   output logic                      out_last,
   input  wire logic                 out_ready
);
   localparam int CW = dsh_pkg::CW;
   localparam int HW = dsh_pkg::HW;
   dsh_pkg::back_state_type st_ff, st_in;
   logic [1:0] k_ff, k_in;         // corner or neighbour index
   logic       rdv_ff, rdv_in;     // a read was issued last cycle
   logic       rdn_ff, rdn_in;     // whether the neighbour just read counts toward the sum
   logic signed [HW+2:0] sum_ff, sum_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [CW-1:0] orow_ff, orow_in, ocol_ff, ocol_in;
   logic signed [HW-1:0] oh_ff, oh_in;
   logic olast_ff, olast_in, ov_ff, ov_in;
   logic we;
   logic [dsh_pkg::AW-1:0] addr;
   logic [HW-1:0] wdata, rdata;
   logic [CW-1:0] pr, pc, nr, nc;
   logic nuse;
   logic signed [HW+2:0] avg, h;
   logic signed [HW:0] noise;
   logic [HW:0] mag;               // magnitude of the neighbour sum
   logic [2*HW:0] prod;
   logic signed [HW+2:0] third;

   dsh_ram #(.WIDTH(HW), .DEPTH(dsh_pkg::SIDE_MAX * dsh_pkg::SIDE_MAX)) u_ram (
      .clock(clock), .wr_en(we), .addr(addr), .wr_data(wdata), .rd_data(rdata));

   assign out_valid = ov_ff;
   assign out_row = orow_ff;
   assign out_col = ocol_ff;
   assign out_height = oh_ff;
   assign out_last = olast_ff;

   // Target point of a displacement command.
   assign pr = cmd.diamond ? cmd.row : cmd.row + cmd.half;
   assign pc = cmd.diamond ? cmd.col : cmd.col + cmd.half;

   always_comb begin
      // Neighbour k: square uses the corner points, diamond the edge points inside the map.
      nuse = 1'b1;
      nr = pr; nc = pc;
      case (k_ff)
         2'd0: begin
            if (cmd.diamond) begin nr = pr - cmd.half; nuse = pr != '0; end
            else begin nr = pr - cmd.half; nc = pc - cmd.half; end
         end
         2'd1: begin
            if (cmd.diamond) begin nc = pc - cmd.half; nuse = pc != '0; end
            else begin nr = pr - cmd.half; nc = pc + cmd.half; end
         end
         2'd2: begin
            if (cmd.diamond) begin nr = pr + cmd.half; nuse = pr != cmd.side_m1; end
            else begin nr = pr + cmd.half; nc = pc - cmd.half; end
         end
         default: begin
            if (cmd.diamond) begin nc = pc + cmd.half; nuse = pc != cmd.side_m1; end
            else begin nr = pr + cmd.half; nc = pc + cmd.half; end
         end
      endcase
   end

   always_comb begin
      st_in = st_ff; k_in = k_ff; rdv_in = 1'b0; rdn_in = rdn_ff;
      sum_in = sum_ff; cnt_in = cnt_ff;
      orow_in = orow_ff; ocol_in = ocol_ff; oh_in = oh_ff; olast_in = olast_ff;
      ov_in = ov_ff && !out_ready;
      cmd_ready = 1'b0;
      we = 1'b0; addr = dsh_pkg::addr_of(nr, nc); wdata = '0;
      avg = '0; h = '0;
      noise = $signed({1'b0, cmd.rnd}) - 17'sd32768;
      // Division by three toward zero: divide the magnitude by reciprocal multiplication.
      mag = (HW+1)'(sum_ff[HW+2] ? -sum_ff : sum_ff);
      prod = (2*HW+1)'(mag) * (2*HW+1)'(dsh_pkg::THIRD_RECIP);
      third = (HW+3)'({1'b0, prod[2*HW:HW+1]});
      if (rdv_ff && rdn_ff) begin
         sum_in = sum_ff + (HW+3)'($signed(rdata));
      end
      case (st_ff)
         dsh_pkg::ST_IDLE: begin
            k_in = '0; sum_in = '0; cnt_in = '0;
            if (cmd_valid) st_in = cmd.start ? dsh_pkg::ST_CORNER : dsh_pkg::ST_READ;
         end
         dsh_pkg::ST_CORNER: begin
            // One corner per result; wait while the output slot is full.
            if (!ov_in) begin
               orow_in = (k_ff == 2'd2 || k_ff == 2'd3) ? cmd.side_m1 : '0;
               ocol_in = (k_ff == 2'd1 || k_ff == 2'd2) ? cmd.side_m1 : '0;
               oh_in = dsh_pkg::HALF_Q; olast_in = 1'b0; ov_in = 1'b1;
               we = 1'b1; addr = dsh_pkg::addr_of(orow_in, ocol_in); wdata = dsh_pkg::HALF_Q;
               k_in = k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  cmd_ready = 1'b1; st_in = dsh_pkg::ST_IDLE;
               end
            end
         end
         dsh_pkg::ST_READ: begin
            rdv_in = 1'b1; rdn_in = nuse;
            if (nuse) cnt_in = cnt_ff + 3'd1;
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) st_in = dsh_pkg::ST_CALC;
         end
         dsh_pkg::ST_CALC: begin
            // Last read lands this cycle; sum_in is complete.
            st_in = dsh_pkg::ST_EMIT;
         end
         dsh_pkg::ST_EMIT: begin
            if (!ov_in) begin
               avg = (cnt_ff == 3'd4) ? sum_ff >>> 2 : sum_ff;
               if (cnt_ff == 3'd4 && sum_ff < 0 && sum_ff[1:0] != 2'b00) avg = avg + 19'sd1;
               if (cnt_ff == 3'd3) avg = sum_ff[HW+2] ? -third : third;
               h = avg + (HW+3)'(noise >>> cmd.shift);
               if (h > 19'sd32767) h = 19'sd32767;
               if (h < -19'sd32768) h = -19'sd32768;
               oh_in = h[HW-1:0]; orow_in = pr; ocol_in = pc;
               olast_in = cmd.last; ov_in = 1'b1;
               we = 1'b1; addr = dsh_pkg::addr_of(pr, pc); wdata = h[HW-1:0];
               cmd_ready = 1'b1; st_in = dsh_pkg::ST_IDLE;
            end
         end
         default: st_in = dsh_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      orow_ff <= orow_in; ocol_ff <= ocol_in; oh_ff <= oh_in; olast_ff <= olast_in;
      sum_ff <= sum_in; cnt_ff <= cnt_in; k_ff <= k_in; rdn_ff <= rdn_in;
      if (reset) begin
         st_ff <= dsh_pkg::ST_IDLE; ov_ff <= 1'b0; rdv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in; rdv_ff <= rdv_in;
      end
   end

   `ASSERT_CLK(a_write_fills, clock, reset, we |=> out_valid, "store write without result")
   `ASSERT_CLK(a_done_idle, clock, reset, cmd_ready |=> (st_ff == dsh_pkg::ST_IDLE), "no return to idle")
   `ASSERT_CLK(a_cnt_range, clock, reset, cnt_ff <= 3'd4, "neighbour count too large")
endmodule
`default_nettype wire

>>> bench/heightmap_checker.sv
// Checker for the height map generator: watches the channels, predicts heights and compares.
module heightmap_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  logic              req_kind,
   input  logic [15:0]       req_random_value,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  logic [8:0]        rsp_row,
   input  logic [8:0]        rsp_col,
   input  logic signed [15:0] rsp_height,
   input  logic              rsp_last,
   input  logic              csr_we,
   input  logic [3:0]        csr_wdata,
   output int                failures,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [8:0]        row;
      logic [8:0]        col;
      logic signed [15:0] height;
      logic              last;
   } point_type;

   point_type points_due[$];
   logic signed [15:0] heights[dsh_pkg::SIDE_MAX * dsh_pkg::SIDE_MAX];
   logic [3:0] order_reg;
   int map_order, step, nshift, row_at, col_at, parity;
   bit diamond, running;

   function automatic int height_at(input int r, input int c);
      int i;
      i = r * dsh_pkg::SIDE_MAX + c;
      if (i >= dsh_pkg::SIDE_MAX * dsh_pkg::SIDE_MAX) return 0;
      return int'(heights[i]);
   endfunction

   function automatic void set_point(input int r, input int c, input int h, input bit last);
      point_type p;
      heights[r * dsh_pkg::SIDE_MAX + c] = 16'(h);
      p.row = 9'(r);
      p.col = 9'(c);
      p.height = 16'(h);
      p.last = last;
      points_due.push_back(p);
   endfunction

   function automatic void displace(input bit start, input logic [15:0] sample);
      int side, half, pr, pc, total, count, h;
      bit last;
      last = 0;
      if (!start) begin
         if (!running) return;
         side = (1 << map_order) + 1;
         half = step >> 1;
         total = 0;
         count = 0;
         if (!diamond) begin
            pr = row_at + half;
            pc = col_at + half;
            total = height_at(row_at, col_at) + height_at(row_at, col_at + step)
               + height_at(row_at + step, col_at) + height_at(row_at + step, col_at + step);
            count = 4;
         end else begin
            pr = row_at;
            pc = col_at;
            if (pr > 0) begin total += height_at(pr - half, pc); count++; end
            if (pc > 0) begin total += height_at(pr, pc - half); count++; end
            if (pr < side - 1) begin total += height_at(pr + half, pc); count++; end
            if (pc < side - 1) begin total += height_at(pr, pc + half); count++; end
         end
         h = (count > 0 ? total / count : 0) + ((int'(sample) - 32768) >>> nshift);
         if (h > 32767) h = 32767;
         if (h < -32768) h = -32768;
         if (!diamond) begin
            col_at += step;
            if (col_at >= side - 1) begin
               col_at = 0;
               row_at += step;
               if (row_at >= side - 1) begin
                  diamond = 1;
                  row_at = 0;
                  parity = 0;
                  col_at = half;
               end
            end
         end else begin
            col_at += step;
            if (col_at >= side) begin
               row_at += half;
               parity ^= 1;
               col_at = parity ? 0 : half;
               if (row_at >= side) begin
                  step >>= 1;
                  nshift = (nshift + 1) & 15;
                  diamond = 0;
                  row_at = 0;
                  col_at = 0;
                  parity = 0;
                  if (step <= 1) begin
                     running = 0;
                     last = 1;
                  end
               end
            end
         end
         set_point(pr, pc, h, last);
      end else begin
         map_order = order_reg == 0 ? 1
            : (order_reg > dsh_pkg::MAX_ORDER ? dsh_pkg::MAX_ORDER : order_reg);
         side = (1 << map_order) + 1;
         set_point(0, 0, dsh_pkg::HALF_Q, 0);
         set_point(0, side - 1, dsh_pkg::HALF_Q, 0);
         set_point(side - 1, side - 1, dsh_pkg::HALF_Q, 0);
         set_point(side - 1, 0, dsh_pkg::HALF_Q, 0);
         step = side - 1;
         nshift = 2;
         row_at = 0;
         col_at = 0;
         diamond = 0;
         parity = 0;
         running = 1;
      end
   endfunction

   always @(posedge clock) begin
      point_type p;
      if (reset) begin
         order_reg = 4'd8;
         running = 0;
         points_due.delete();
         failures <= 0;
      end else begin
         if (csr_we) order_reg = csr_wdata;
         if (req_push && !req_full) displace(req_kind == 1'b0, req_random_value);
         if (rsp_pop && !rsp_empty) begin
            if (points_due.size() == 0) begin
               if (failures < 10)
                  $display("unexpected transfer: row %0d col %0d height %0d last %0d",
                     rsp_row, rsp_col, rsp_height, rsp_last);
               failures <= failures + 1;
            end else begin
               p = points_due.pop_front();
               if (p.row !== rsp_row || p.col !== rsp_col || p.height !== rsp_height
                     || p.last !== rsp_last) begin
                  if (failures < 10)
                     $display("mismatch: expected (%0d,%0d) %0d last %0d, got (%0d,%0d) %0d last %0d",
                        p.row, p.col, p.height, p.last, rsp_row, rsp_col, rsp_height, rsp_last);
                  failures <= failures + 1;
               end
            end
         end
      end
      pending <= points_due.size();
   end
endmodule

>>> bench/testbench.sv
// Top of the height map generator bench: clock, reset, stimulus and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock, reset;
   logic req_push, req_full, req_kind;
   logic [15:0] req_random_value;
   logic rsp_empty, rsp_pop, rsp_last;
   logic [8:0] rsp_row, rsp_col;
   logic signed [15:0] rsp_height;
   logic csr_we;
   logic [3:0] csr_wdata;
   int failures, pending;
   bit calm;

   diamond_square_heightmap dut (.*);
   heightmap_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls now and then, except during the calm stretch.
   always @(posedge clock) rsp_pop <= calm || $urandom_range(99) >= 9;

   task automatic send(input logic kind, input logic [15:0] sample);
      if (!calm && $urandom_range(99) < 9) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_kind <= kind;
      req_random_value <= sample;
      do @(posedge clock); while (req_full);
   endtask

   function automatic logic [15:0] noise_sample();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic quiesce();
      req_push <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_order(input logic [3:0] order);
      quiesce();
      csr_we <= 1'b1;
      csr_wdata <= order;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic build_map(input logic [3:0] order, input int samples);
      set_order(order);
      send(1'b0, 16'($urandom));
      repeat (samples) send(1'b1, noise_sample());
   endtask

   initial begin
      reset = 1;
      req_push = 0;
      req_kind = 0;
      req_random_value = 0;
      csr_we = 0;
      csr_wdata = 0;
      calm = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // A sample before any start must be ignored.
      send(1'b1, 16'hFFFF);
      // Order zero runs as order one; extremes of the sample.
      set_order(4'd0);
      send(1'b0, 16'hFFFF);
      send(1'b1, 16'h0000);
      send(1'b1, 16'hFFFF);
      // A start in the middle of a map restarts it from the corners.
      send(1'b0, 16'h0000);
      send(1'b1, 16'h8000);
      send(1'b1, 16'h7FFF);
      send(1'b1, 16'h0001);
      send(1'b1, 16'hFFFE);
      send(1'b1, 16'h5555);
      send(1'b1, 16'hAAAA);
      // Samples after the map is complete are ignored.
      send(1'b1, 16'h1234);
      // Order above the maximum is clamped; a few points only, then restarted.
      build_map(4'd15, 3);
      build_map(4'd2, 21);
      calm = 1;
      build_map(4'd3, 40);
      calm = 0;
      repeat (37) send(1'b1, noise_sample());
      quiesce();
      repeat ($urandom_range(30)) @(posedge clock);
      repeat (2) send(1'b1, noise_sample());
      quiesce();
      if (failures == 0)
         $display("diamond_square_heightmap test passed");
      else
         $display("diamond_square_heightmap test failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("diamond_square_heightmap test failed");
      $finish;
   end
endmodule
